[rtl/mmf_pkg.sv]
// mmf_pkg: shared types and constants of the masked 3x3 median filter.
// Used by the channel interfaces, the top level, the median pipeline and the checker.
package mmf_pkg;

  localparam int PIX_W     = 8;
  localparam int COL_OUT_W = 11;
  localparam int ROW_OUT_W = 12;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 13;
  localparam int IMG_W_W   = 12;
  localparam int IMG_H_W   = 13;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

  typedef logic [PIX_W-1:0] pix_t;

  localparam pix_t PIX_WHITE = 8'hFF;
  localparam pix_t PIX_ZERO  = 8'h00;

  // one stored pixel: grey level plus mask bit
  typedef struct packed {
    logic mask;
    pix_t pix;
  } ent_t;

  // one line memory word: rows r-2 and r-1 at the same column
  typedef struct packed {
    ent_t upper;
    ent_t middle;
  } line_ent_t;

  // 3x3 neighborhood in network order
  typedef pix_t [8:0] nine_t;

  // sideband that travels with a window through the median pipeline
  typedef struct packed {
    logic [COL_OUT_W-1:0] col;
    logic [ROW_OUT_W-1:0] row;
    logic                 last;
    logic                 interior;
    logic                 masked;
  } res_tag_t;

endpackage

[rtl/mmf_if.sv]
// mmf_if: valid/ready channel interfaces for pixel and result requests.
// Depends on mmf_pkg.
interface mmf_pixel_if import mmf_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel_value;
  logic mask_black;

  modport source(output valid, pixel_value, mask_black, input ready);
  modport sink(input valid, pixel_value, mask_black, output ready);
endinterface

interface mmf_result_if import mmf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  pix_t                 filtered_value;
  logic [COL_OUT_W-1:0] centre_column;
  logic [ROW_OUT_W-1:0] centre_row;
  logic                 frame_last;

  modport source(output valid, filtered_value, centre_column, centre_row, frame_last,
                 input ready);
  modport sink(input valid, filtered_value, centre_column, centre_row, frame_last,
               output ready);
endinterface

[rtl/masked_median3x3_filter.sv]
// masked_median3x3_filter: top level with line memory, 3x3 window and raster counters.
// Depends on mmf_pkg, mmf_if (channel interfaces) and mmf_median9.
//
// Usage: pixel requests (grey level + mask bit) enter on "pixels" in raster order,
// one per clock when the block is not stalled. Each pixel at row >= 1 and column >= 1
// completes the window of centre (row-1, column-1) and yields one result request on
// "results"; other pixels yield none. Interior centres with a black mask give the
// median of their 3x3 neighborhood, other interior centres 255, centres on row 0 or
// column 0 give 0; frame_last marks centre (height-2, width-2).
// A result is registered through stage 1 and the median stages a, b and c.
// Throughput: one pixel per clock unless stalled; each pixel does one read and one
// write of the shared line memory, which holds two rows side by side in one word.
// Reset clears the counters, the window and the pipeline and restores width 640 and
// height 480; the line memory is not cleared (the first two rows of a frame refill it).
// If the receiver stalls, four internal stages fill up and then pixels.ready drops;
// it rises again in the cycle results.ready does. The user must write configuration
// (cfg_write/cfg_index/cfg_data) while no pixels are in flight; no logic enforces it.
module masked_median3x3_filter import mmf_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  mmf_pixel_if.sink            pixels,
  mmf_result_if.source         results,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
  localparam int HW = (RW + 1 > IMG_H_W) ? RW + 1 : IMG_H_W;

  logic [IMG_W_W-1:0] image_width;
  logic [IMG_H_W-1:0] image_height;
  logic [CW-1:0]      column_count;
  logic [RW-1:0]      row_count;

  logic [WW-1:0] w_raw, w_eff;
  logic [HW-1:0] h_raw, h_eff;
  logic          col_wrap, row_wrap, col_last, row_last;
  logic          accept;

  line_ent_t line_mem [MAX_WIDTH];
  line_ent_t rd_data;

  logic          s1_valid, s1_go, s1_emit, s1_last;
  ent_t          s1_bot;
  logic [CW-1:0] s1_col;
  logic [RW-1:0] s1_row;
  ent_t          win [6];

  nine_t    med_vals;
  res_tag_t med_tag, out_tag;
  logic     med_ready;
  pix_t     out_value;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_W_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[IMG_H_W-1:0];
      endcase
    end
  end

  // clamp frame size into 3..MAX
  always_comb begin
    w_raw = WW'(image_width);
    h_raw = HW'(image_height);
    if (w_raw < WW'(3))              w_eff = WW'(3);
    else if (w_raw > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else                             w_eff = w_raw;
    if (h_raw < HW'(3))               h_eff = HW'(3);
    else if (h_raw > HW'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
    else                              h_eff = h_raw;
  end

  assign col_wrap = (WW'(column_count) + WW'(1)) >= w_eff;
  assign row_wrap = (HW'(row_count) + HW'(1)) >= h_eff;
  assign col_last = WW'(column_count) == (w_eff - WW'(1));
  assign row_last = HW'(row_count) == (h_eff - HW'(1));

  // stage 1 leaves when it makes no result or the median pipeline takes it
  assign s1_emit       = (s1_row != '0) && (s1_col != '0);
  assign s1_go         = s1_valid && (!s1_emit || med_ready);
  assign pixels.ready  = !s1_valid || s1_go;
  assign accept        = pixels.valid && pixels.ready;

  // raster position of the next pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        column_count <= '0;
        row_count    <= row_wrap ? '0 : row_count + RW'(1);
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  // line memory: read at accept, write back when the pixel leaves stage 1.
  // Consecutive pixels never share a column, so the two ports never collide.
  always_ff @(posedge clk) begin
    if (s1_go) begin
      line_mem[s1_col] <= '{upper: rd_data.middle, middle: s1_bot};
    end
    if (accept) begin
      rd_data <= line_mem[column_count];
    end
  end

  // stage 1 holds the pixel while its memory word is on the read port
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bot  <= '{mask: pixels.mask_black, pix: pixels.pixel_value};
      s1_col  <= column_count;
      s1_row  <= row_count;
      s1_last <= col_last && row_last;
    end
  end

  // window shift: two previous columns, top/middle/bottom each
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '{default: '0};
    end else if (s1_go) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= rd_data.upper;
      win[4] <= rd_data.middle;
      win[5] <= s1_bot;
    end
  end

  // neighborhood and sideband for the median pipeline
  always_comb begin
    med_vals[0]      = win[0].pix;
    med_vals[1]      = win[3].pix;
    med_vals[2]      = rd_data.upper.pix;
    med_vals[3]      = win[1].pix;
    med_vals[4]      = win[4].pix;
    med_vals[5]      = rd_data.middle.pix;
    med_vals[6]      = win[2].pix;
    med_vals[7]      = win[5].pix;
    med_vals[8]      = s1_bot.pix;
    med_tag.col      = COL_OUT_W'(s1_col - CW'(1));
    med_tag.row      = ROW_OUT_W'(s1_row - RW'(1));
    med_tag.last     = s1_last;
    med_tag.interior = (s1_col > CW'(1)) && (s1_row > RW'(1));
    med_tag.masked   = win[4].mask;
  end

  mmf_median9 u_median (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid && s1_emit),
    .in_ready  (med_ready),
    .in_vals   (med_vals),
    .in_tag    (med_tag),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_value (out_value),
    .out_tag   (out_tag)
  );

  assign results.filtered_value = out_value;
  assign results.centre_column  = out_tag.col;
  assign results.centre_row     = out_tag.row;
  assign results.frame_last     = out_tag.last;

endmodule

[rtl/mmf_median9.sv]
// mmf_median9: three-stage pipelined 19-exchange median-of-nine network
// with final border/mask selection. Depends on mmf_pkg.
module mmf_median9 import mmf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  nine_t    in_vals,
  input  res_tag_t in_tag,
  output logic     out_valid,
  input  logic     out_ready,
  output pix_t     out_value,
  output res_tag_t out_tag
);

  // compare-exchange: smaller value ends at position i
  function automatic nine_t cx(nine_t v, int unsigned i, int unsigned j);
    nine_t r;
    r = v;
    if (v[i] > v[j]) begin
      r[i] = v[j];
      r[j] = v[i];
    end
    return r;
  endfunction

  logic     a_valid, b_valid, c_valid;
  logic     a_ready, b_ready, c_ready;
  nine_t    a_vals, b_vals;
  nine_t    a_next, b_next, c_sorted;
  res_tag_t a_tag, b_tag, c_tag;
  pix_t     c_value, c_next;

  // stall chain: a stage loads when it is empty or its content moves on
  assign c_ready  = !c_valid || out_ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  // row sorts (three exchange layers)
  always_comb begin
    a_next = in_vals;
    a_next = cx(a_next, 1, 2);
    a_next = cx(a_next, 4, 5);
    a_next = cx(a_next, 7, 8);
    a_next = cx(a_next, 0, 1);
    a_next = cx(a_next, 3, 4);
    a_next = cx(a_next, 6, 7);
    a_next = cx(a_next, 1, 2);
    a_next = cx(a_next, 4, 5);
    a_next = cx(a_next, 7, 8);
  end

  // cross-row layers
  always_comb begin
    b_next = a_vals;
    b_next = cx(b_next, 0, 3);
    b_next = cx(b_next, 5, 8);
    b_next = cx(b_next, 4, 7);
    b_next = cx(b_next, 3, 6);
    b_next = cx(b_next, 1, 4);
    b_next = cx(b_next, 2, 5);
    b_next = cx(b_next, 4, 7);
  end

  // final diagonal exchanges and result selection
  always_comb begin
    c_sorted = b_vals;
    c_sorted = cx(c_sorted, 4, 2);
    c_sorted = cx(c_sorted, 6, 4);
    c_sorted = cx(c_sorted, 4, 2);
    if (!b_tag.interior) begin
      c_next = PIX_ZERO;
    end else if (b_tag.masked) begin
      c_next = c_sorted[4];
    end else begin
      c_next = PIX_WHITE;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= in_valid;
      if (b_ready) b_valid <= a_valid;
      if (c_ready) c_valid <= b_valid;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_vals <= a_next;
      a_tag  <= in_tag;
    end
    if (b_ready && a_valid) begin
      b_vals <= b_next;
      b_tag  <= a_tag;
    end
    if (c_ready && b_valid) begin
      c_value <= c_next;
      c_tag   <= b_tag;
    end
  end

  assign out_valid = c_valid;
  assign out_value = c_value;
  assign out_tag   = c_tag;

endmodule

[rtl/mmf_checker.sv]
// mmf_checker: port-level assertions for masked_median3x3_filter, bound to the top level.
// Depends on mmf_pkg.
module mmf_checker import mmf_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 pix_ready,
  input logic                 res_valid,
  input logic                 res_ready,
  input pix_t                 res_value,
  input logic [COL_OUT_W-1:0] res_col,
  input logic [ROW_OUT_W-1:0] res_row,
  input logic                 res_last
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // a free or draining output must never back-pressure pixels
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    (!res_valid || res_ready) |-> pix_ready)
    else $error("pixel request stalled while output can move");

  // a stalled result request keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid && $stable(res_value) && $stable(res_col)
                                   && $stable(res_row) && $stable(res_last))
    else $error("stalled result request changed");

  // border centres give zero
  a_border_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_row == '0 || res_col == '0)) |-> res_value == PIX_ZERO)
    else $error("border centre not zero");

  // the frame's last centre is always interior
  a_last_interior: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_last) |-> (res_row != '0) && (res_col != '0))
    else $error("frame end flagged on a border centre");

endmodule

bind masked_median3x3_filter mmf_checker u_mmf_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_ready (pixels.ready),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_value (results.filtered_value),
  .res_col   (results.centre_column),
  .res_row   (results.centre_row),
  .res_last  (results.frame_last)
);
